// File: sv/ppd_pkg.sv
package ppd_pkg;

  localparam int WRAP_STEPS_DEF = 2;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int POS_W          = 31;
  localparam int VEL_W          = 32;
  localparam int PROD_W         = 65;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_W          = 32;
  localparam int DX_W           = 37;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_JUMP   = 2'd1,
    ST_SMOOTH = 2'd2,
    ST_WRAP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_SKIP    = 3'd0,
    CLS_GAS     = 3'd1,
    CLS_BH      = 3'd2,
    CLS_BH_JUMP = 3'd3,
    CLS_OTHER   = 3'd4
  } pclass_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIFT   = 3'd0,
    REG_BOX     = 3'd1,
    REG_REPOS   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                         is_gas;
    logic                         jump_far;
    logic [2:0][POS_W-1:0]        pos;
    logic [2:0][VEL_W-1:0]        vel;
    logic [POS_W-1:0]             hsml;
  } mid_t;

  typedef struct packed {
    logic [2:0][VEL_W-1:0]        vel;
    logic [POS_W-1:0]             hsml;
    status_t                      status;
  } tail_t;

endpackage

// File: sv/periodic_particle_drift.sv
// Streaming particle drift unit: one particle may be started in every clock cycle and busy
// never rises. Each particle gives exactly one result, shown for one cycle with done; the path
// from the start transfer to done runs through the input register with the jump check, the
// two-stage multiplier, the summing stage, one register stage per box-wrap step and the final
// clamp. The receiver cannot stall, so results must be taken as they appear. Configuration
// writes are always ready and must only be made while no particle is in flight.
module periodic_particle_drift #(
  parameter int WRAP_STEPS = ppd_pkg::WRAP_STEPS_DEF,
  parameter int FRAC_BITS  = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        particle_class,
  input  logic [ppd_pkg::POS_W-1:0]         pos_x,
  input  logic [ppd_pkg::POS_W-1:0]         pos_y,
  input  logic [ppd_pkg::POS_W-1:0]         pos_z,
  input  logic signed [ppd_pkg::VEL_W-1:0]  vel_x,
  input  logic signed [ppd_pkg::VEL_W-1:0]  vel_y,
  input  logic signed [ppd_pkg::VEL_W-1:0]  vel_z,
  input  logic [ppd_pkg::POS_W-1:0]         target_x,
  input  logic [ppd_pkg::POS_W-1:0]         target_y,
  input  logic [ppd_pkg::POS_W-1:0]         target_z,
  input  logic [ppd_pkg::POS_W-1:0]         smoothing_length,
  input  logic signed [ppd_pkg::VEL_W-1:0]  smoothing_rate,
  output logic                              done,
  output logic [ppd_pkg::POS_W-1:0]         new_x,
  output logic [ppd_pkg::POS_W-1:0]         new_y,
  output logic [ppd_pkg::POS_W-1:0]         new_z,
  output logic signed [ppd_pkg::VEL_W-1:0]  out_vel_x,
  output logic signed [ppd_pkg::VEL_W-1:0]  out_vel_y,
  output logic signed [ppd_pkg::VEL_W-1:0]  out_vel_z,
  output logic [ppd_pkg::POS_W-1:0]         new_smoothing,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppd_pkg::CFG_W-1:0]         cfg_data
);
  import ppd_pkg::*;

  localparam int SCALE_W = PROD_W - FRAC_BITS;
  localparam int AW      = SCALE_W + 2;

  logic [31:0]        drift_factor;
  logic [POS_W-1:0]   box_size;
  logic               reposition_enable;
  logic [2:0][31:0]   shift;
  logic [POS_W-1:0]   box_eff;

  logic [2:0][POS_W-1:0] pos_in;
  logic [2:0][POS_W-1:0] tgt_in;
  logic [2:0][VEL_W-1:0] vel_in;

  logic [2:0]            mvalid;
  mid_t                  mid [3];
  mid_t                  mid_next;
  logic [2:0][VEL_W-1:0] sv;
  logic [VEL_W-1:0]      srate;
  logic [2:0][VEL_W-1:0] sv_next;
  logic [VEL_W-1:0]      srate_next;
  logic [2:0][SCALE_W-1:0] scaled;
  logic [SCALE_W-1:0]      scaled_rate;

  logic [WRAP_STEPS:0]            wvalid;
  logic [2:0][AW-1:0]             wpos [WRAP_STEPS+1];
  tail_t                          tail [WRAP_STEPS+1];
  logic [2:0][AW-1:0]             wsum_next;
  tail_t                          tail_next;

  logic [2:0][POS_W-1:0] fin_pos;
  logic                  fin_bad;
  status_t               stat_out;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign box_eff   = (box_size == '0) ? POS_W'(1) : box_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_factor      <= '0;
      box_size          <= POS_W'(1);
      reposition_enable <= 1'b0;
      shift             <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRIFT:   drift_factor      <= cfg_data;
        REG_BOX:     box_size          <= cfg_data[POS_W-1:0];
        REG_REPOS:   reposition_enable <= cfg_data[0];
        REG_SHIFT_X: shift[0]          <= cfg_data;
        REG_SHIFT_Y: shift[1]          <= cfg_data;
        REG_SHIFT_Z: shift[2]          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pos_in = {pos_z, pos_y, pos_x};
  assign tgt_in = {target_z, target_y, target_x};
  assign vel_in = {vel_z, vel_y, vel_x};

  always_comb begin
    logic              use_tgt;
    logic              skip;
    logic              gas;
    logic              far;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] bs;
    skip    = (particle_class == CLS_SKIP);
    gas     = (particle_class == CLS_GAS);
    use_tgt = (particle_class == CLS_BH_JUMP) && reposition_enable;
    bs      = $signed({{(DX_W-POS_W){1'b0}}, box_eff});
    far     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dx = $signed({{(DX_W-POS_W){1'b0}}, pos_in[k]}) -
           $signed({{(DX_W-POS_W){1'b0}}, tgt_in[k]});
      if ((dx <<< 1) > bs) begin
        dx = dx - bs;
      end else if ((dx <<< 1) < -bs) begin
        dx = dx + bs;
      end
      if (((dx <<< 3) + (dx <<< 1)) > bs) begin
        far = 1'b1;
      end
    end
    mid_next.is_gas   = gas;
    mid_next.jump_far = use_tgt && far;
    mid_next.pos      = use_tgt ? tgt_in : pos_in;
    mid_next.vel      = vel_in;
    mid_next.hsml     = smoothing_length;
    sv_next           = skip ? '0 : vel_in;
    srate_next        = gas ? smoothing_rate : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= '0;
    end else begin
      mvalid <= {mvalid[1:0], start && !busy};
    end
    mid[0] <= mid_next;
    mid[1] <= mid[0];
    mid[2] <= mid[1];
    sv     <= sv_next;
    srate  <= srate_next;
  end

  for (genvar k = 0; k < 3; k++) begin : g_scale
    ppd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clk    (clk),
      .value  (sv[k]),
      .factor (drift_factor),
      .scaled (scaled[k])
    );
  end

  ppd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_rate (
    .clk    (clk),
    .value  (srate),
    .factor (drift_factor),
    .scaled (scaled_rate)
  );

  always_comb begin
    logic signed [AW-1:0] h;
    logic signed [AW-1:0] half;
    half = $signed({{(AW-POS_W){1'b0}}, box_eff >> 1});
    for (int k = 0; k < 3; k++) begin
      wsum_next[k] = $signed({{(AW-POS_W){1'b0}}, mid[2].pos[k]}) +
                     $signed({{(AW-SCALE_W){scaled[k][SCALE_W-1]}}, scaled[k]}) +
                     $signed({{(AW-32){shift[k][31]}}, shift[k]});
    end
    h = $signed({{(AW-POS_W){1'b0}}, mid[2].hsml}) +
        $signed({{(AW-SCALE_W){scaled_rate[SCALE_W-1]}}, scaled_rate});
    tail_next.vel = mid[2].vel;
    if (mid[2].jump_far) begin
      tail_next.status = ST_JUMP;
    end else if (mid[2].is_gas && h <= 0) begin
      tail_next.status = ST_SMOOTH;
    end else begin
      tail_next.status = ST_OK;
    end
    if (!mid[2].is_gas) begin
      tail_next.hsml = mid[2].hsml;
    end else if (h <= 0) begin
      tail_next.hsml = '0;
    end else if (h > half) begin
      tail_next.hsml = box_eff >> 1;
    end else begin
      tail_next.hsml = h[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid[0] <= 1'b0;
    end else begin
      wvalid[0] <= mvalid[2];
    end
    wpos[0] <= wsum_next;
    tail[0] <= tail_next;
  end

  for (genvar i = 0; i < WRAP_STEPS; i++) begin : g_wrap
    ppd_wrap #(.AW(AW)) u_wrap (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (wvalid[i]),
      .in_pos    (wpos[i]),
      .box       (box_eff),
      .out_valid (wvalid[i+1]),
      .out_pos   (wpos[i+1])
    );
    always_ff @(posedge clk) begin
      tail[i+1] <= tail[i];
    end
  end

  always_comb begin
    logic signed [AW-1:0] p;
    logic signed [AW-1:0] b;
    b       = $signed({{(AW-POS_W){1'b0}}, box_eff});
    fin_bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p = $signed(wpos[WRAP_STEPS][k]);
      if (p > b) begin
        fin_pos[k] = box_eff;
        fin_bad    = 1'b1;
      end else if (p <= 0) begin
        fin_pos[k] = POS_W'(1);
        fin_bad    = 1'b1;
      end else begin
        fin_pos[k] = p[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wvalid[WRAP_STEPS];
    end
    new_x         <= fin_pos[0];
    new_y         <= fin_pos[1];
    new_z         <= fin_pos[2];
    out_vel_x     <= tail[WRAP_STEPS].vel[0];
    out_vel_y     <= tail[WRAP_STEPS].vel[1];
    out_vel_z     <= tail[WRAP_STEPS].vel[2];
    new_smoothing <= tail[WRAP_STEPS].hsml;
    if (tail[WRAP_STEPS].status != ST_OK) begin
      stat_out <= tail[WRAP_STEPS].status;
    end else if (fin_bad) begin
      stat_out <= ST_WRAP;
    end else begin
      stat_out <= ST_OK;
    end
  end

  assign status = stat_out;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(WRAP_STEPS + 5) done)
    else $error("result strobe missing after start");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(wvalid[WRAP_STEPS]))
    else $error("result strobe without a particle in the last stage");

  a_smooth_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SMOOTH) |-> new_smoothing == '0)
    else $error("non-positive smoothing length not cleared");

endmodule

// File: sv/ppd_scale.sv
module ppd_scale #(
  parameter int FRAC_BITS = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic [ppd_pkg::VEL_W-1:0]                        value,
  input  logic [31:0]                                      factor,
  output logic [ppd_pkg::PROD_W-FRAC_BITS-1:0]             scaled
);
  import ppd_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  always_ff @(posedge clk) begin
    prod <= $signed({{(PROD_W-VEL_W){value[VEL_W-1]}}, value}) *
            $signed({{(PROD_W-32){1'b0}}, factor});
    scaled <= biased[PROD_W-1:FRAC_BITS];
  end

  assign biased = prod + $signed({{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));

endmodule

// File: sv/ppd_wrap.sv
module ppd_wrap #(
  parameter int AW = 53
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [2:0][AW-1:0]                in_pos,
  input  logic [ppd_pkg::POS_W-1:0]         box,
  output logic                              out_valid,
  output logic [2:0][AW-1:0]                out_pos
);
  import ppd_pkg::*;

  logic [2:0][AW-1:0] pos_next;

  always_comb begin
    logic signed [AW-1:0] p;
    logic signed [AW-1:0] b;
    b = $signed({{(AW-POS_W){1'b0}}, box});
    for (int k = 0; k < 3; k++) begin
      p = $signed(in_pos[k]);
      if (p > b) begin
        pos_next[k] = p - b;
      end else if (p <= 0) begin
        pos_next[k] = p + b;
      end else begin
        pos_next[k] = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_pos <= pos_next;
  end

endmodule

// File: tb/sv/tb_periodic_particle_drift.sv
module tb_periodic_particle_drift;
  import ppd_pkg::*;

  localparam int LATENCY = WRAP_STEPS_DEF + 5;

  typedef struct {
    logic [2:0] cls;
    logic [POS_W-1:0] pos [3];
    logic signed [VEL_W-1:0] vel [3];
    logic [POS_W-1:0] tgt [3];
    logic [POS_W-1:0] hsml;
    logic signed [VEL_W-1:0] rate;
  } particle_t;

  typedef struct {
    logic [POS_W-1:0] pos [3];
    logic [VEL_W-1:0] vel [3];
    logic [POS_W-1:0] hsml;
    status_t status;
  } drift_res_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] particle_class = 0;
  logic [POS_W-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [VEL_W-1:0] vel_x = 0, vel_y = 0, vel_z = 0;
  logic [POS_W-1:0] target_x = 0, target_y = 0, target_z = 0;
  logic [POS_W-1:0] smoothing_length = 0;
  logic signed [VEL_W-1:0] smoothing_rate = 0;
  logic done;
  logic [POS_W-1:0] new_x, new_y, new_z, new_smoothing;
  logic signed [VEL_W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic [1:0] status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  int mismatches = 0;
  int particles_sent = 0;
  int results_seen = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  periodic_particle_drift u_top (.*);

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  class drift_scoreboard;
    logic [31:0] drift;
    longint box;
    bit repos;
    longint shift [3];
    drift_res_t pending [$];

    function new();
      drift = 0;
      box = 1;
      repos = 0;
      shift = '{0, 0, 0};
    endfunction

    function longint scaled(longint v);
      longint p;
      p = v * longint'({32'b0, drift}) + (64'sd1 <<< (FRAC_BITS_DEF - 1));
      return p >>> FRAC_BITS_DEF;
    endfunction

    function bit wrap(ref longint p);
      for (int s = 0; s < WRAP_STEPS_DEF; s++) begin
        if (p > box) p -= box;
        else if (p <= 0) p += box;
      end
      if (p > box) begin
        p = box;
        return 1;
      end
      if (p <= 0) begin
        p = 1;
        return 1;
      end
      return 0;
    endfunction

    function void note_particle(particle_t it);
      longint p [3];
      longint h, dx;
      bit bad;
      drift_res_t r;
      bad = 0;
      r.status = ST_OK;
      h = it.hsml;
      for (int k = 0; k < 3; k++) p[k] = it.pos[k];
      if (it.cls == CLS_SKIP) begin
        for (int k = 0; k < 3; k++) begin
          p[k] += shift[k];
          if (wrap(p[k])) bad = 1;
        end
      end else begin
        if (it.cls == CLS_BH_JUMP && repos) begin
          for (int k = 0; k < 3; k++) begin
            dx = p[k] - longint'(it.tgt[k]);
            if (2 * dx > box) dx -= box;
            else if (2 * dx < -box) dx += box;
            if (10 * dx > box) r.status = ST_JUMP;
            p[k] = it.tgt[k];
          end
        end else if (it.cls == CLS_GAS) begin
          h += scaled(it.rate);
          if (h <= 0) begin
            r.status = ST_SMOOTH;
            h = 0;
          end else if (2 * h > box) begin
            h = box / 2;
          end
        end
        for (int k = 0; k < 3; k++) begin
          p[k] += scaled(it.vel[k]) + shift[k];
          if (wrap(p[k])) bad = 1;
        end
      end
      if (r.status == ST_OK && bad) r.status = ST_WRAP;
      for (int k = 0; k < 3; k++) begin
        r.pos[k] = p[k][POS_W-1:0];
        r.vel[k] = it.vel[k];
      end
      r.hsml = h[POS_W-1:0];
      pending.push_back(r);
    endfunction

    task check_result(drift_res_t got);
      drift_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got.pos[k] !== w.pos[k]) report($sformatf("new pos %0d", k), got.pos[k], w.pos[k]);
        if (got.vel[k] !== w.vel[k]) report($sformatf("out vel %0d", k), got.vel[k], w.vel[k]);
      end
      if (got.hsml !== w.hsml) report("new_smoothing", got.hsml, w.hsml);
      if (got.status !== w.status) report("status", got.status, w.status);
    endtask
  endclass

  drift_scoreboard sb = new();

  always @(posedge clk) begin
    drift_res_t g;
    if (!rst && done === 1'b1) begin
      g.pos = '{new_x, new_y, new_z};
      g.vel = '{out_vel_x, out_vel_y, out_vel_z};
      g.hsml = new_smoothing;
      g.status = status_t'(status);
      sb.check_result(g);
      results_seen++;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIFT: sb.drift = val;
      REG_BOX: sb.box = (val[30:0] == 0) ? 1 : val[30:0];
      REG_REPOS: sb.repos = val[0];
      REG_SHIFT_X: sb.shift[0] = longint'($signed(val));
      REG_SHIFT_Y: sb.shift[1] = longint'($signed(val));
      default: sb.shift[2] = longint'($signed(val));
    endcase
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_particle(particle_t it, int gap);
    repeat (gap) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    particle_class <= it.cls;
    {pos_x, pos_y, pos_z} <= {it.pos[0], it.pos[1], it.pos[2]};
    {vel_x, vel_y, vel_z} <= {it.vel[0], it.vel[1], it.vel[2]};
    {target_x, target_y, target_z} <= {it.tgt[0], it.tgt[1], it.tgt[2]};
    smoothing_length <= it.hsml;
    smoothing_rate <= it.rate;
    do @(posedge clk); while (busy);
    sb.note_particle(it);
    particles_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [30:0] rand_pos(longint box);
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return 0;
      2: return 31'(box);
      default: return 31'($urandom_range(0, int'(box)));
    endcase
  endfunction

  function automatic particle_t rand_particle(longint box);
    particle_t it;
    it.cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    for (int k = 0; k < 3; k++) begin
      it.pos[k] = rand_pos(box);
      it.tgt[k] = ($urandom_range(0, 1)) ? rand_pos(box) : it.pos[k] + 31'($urandom_range(0, 50));
      it.vel[k] = ($urandom_range(0, 3) == 0) ? $urandom : $signed(32'($urandom_range(0, 4000)) - 2000);
    end
    it.hsml = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1000));
    it.rate = ($urandom_range(0, 3) == 0) ? $urandom : $signed(32'($urandom_range(0, 4000)) - 2000);
    return it;
  endfunction

  initial begin
    particle_t d;
    logic [31:0] drifts [5];
    logic [31:0] boxes [5];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset settings first, then extremes of every class.
    d = '{cls: CLS_GAS, pos: '{0, 1, 31'h7FFFFFFF}, vel: '{32'sh7FFFFFFF, -32'sh80000000, 0},
          tgt: '{0, 0, 0}, hsml: 0, rate: 0};
    send_particle(d, 0);
    drain();
    write_reg(REG_DRIFT, 32'h0001_0000);
    write_reg(REG_BOX, 32'd1000);
    write_reg(REG_REPOS, 32'd1);
    write_reg(REG_SHIFT_X, 32'd5);
    write_reg(REG_SHIFT_Y, -32'sd7);
    write_reg(REG_SHIFT_Z, 32'd0);
    for (int c = 0; c < 8; c++) begin
      d = '{cls: 3'(c), pos: '{500, 1000, 0}, vel: '{10, -20, 3000},
            tgt: '{10, 999, 400}, hsml: 400, rate: 200};
      send_particle(d, 0);
    end
    d = '{cls: CLS_GAS, pos: '{1, 2, 3}, vel: '{0, 0, 0}, tgt: '{0, 0, 0},
          hsml: 5, rate: -32'sd100};
    send_particle(d, 1);
    d.hsml = 31'h7FFFFFFF;
    d.rate = 32'sh7FFFFFFF;
    send_particle(d, 0);
    d = '{cls: CLS_BH_JUMP, pos: '{999, 1, 50}, vel: '{1, 2, 3}, tgt: '{1, 999, 150},
          hsml: 9, rate: 0};
    send_particle(d, 2);
    d = '{cls: CLS_OTHER, pos: '{31'h7FFFFFFF, 0, 31'h7FFFFFFF},
          vel: '{32'sh7FFFFFFF, -32'sh80000000, -32'sd1}, tgt: '{0, 0, 0}, hsml: 1, rate: 0};
    send_particle(d, 0);
    drain();
    write_reg(REG_BOX, 32'd0);
    send_particle(d, 0);
    drain();

    drifts = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0003_4567};
    boxes = '{32'h7FFF_FFFF, 32'd1, 32'd1000000, 32'd65536, 32'd123};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_DRIFT, ph < 5 ? drifts[ph] : $urandom);
      write_reg(REG_BOX, ph < 5 ? boxes[ph] : $urandom_range(1, 100000));
      write_reg(REG_REPOS, ph % 2 == 0);
      write_reg(REG_SHIFT_X, ph == 1 ? 32'h8000_0000 : 32'($urandom_range(0, 200)) - 100);
      write_reg(REG_SHIFT_Y, ph == 1 ? 32'h7FFF_FFFF : $urandom);
      write_reg(REG_SHIFT_Z, 32'($urandom_range(0, 2000)) - 1000);
      for (int i = 0; i < 150; i++)
        send_particle(rand_particle(sb.box), ($urandom_range(0, 2) == 0) ? 0 :
                      $urandom_range(0, 13));
      drain();
    end

    $display("Sent %0d particles across all classes and %0d settings; %0d results checked.",
             particles_sent, 10, results_seen);
    if (mismatches == 0) begin
      $display("tb_periodic_particle_drift: done, clean");
    end else begin
      $display("tb_periodic_particle_drift: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_periodic_particle_drift: done, errors");
    $finish;
  end

endmodule
